### rtl/core/mpbp_pkg.sv
// ----------------------------------------------------------------------------
// mpbp_pkg
// Shared types and codes of the publish body parser: parse phases, byte
// classes, error codes and the request and response item layouts.
// ----------------------------------------------------------------------------
package mpbp_pkg;

   // parse phase, one-hot
   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_TLEN    = 7'b0000010,
      PH_TOPIC   = 7'b0000100,
      PH_PKTID   = 7'b0001000,
      PH_PAYLOAD = 7'b0010000,
      PH_DONE    = 7'b0100000,
      PH_FAIL    = 7'b1000000
   } phase_type;

   // byte classes
   localparam logic [2:0] CLS_TLEN    = 3'd0;
   localparam logic [2:0] CLS_TOPIC   = 3'd1;
   localparam logic [2:0] CLS_PKTID   = 3'd2;
   localparam logic [2:0] CLS_PAYLOAD = 3'd3;
   localparam logic [2:0] CLS_NONE    = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_ZERO_TOPIC = 2'd1;
   localparam logic [1:0] ERR_SHORT      = 2'd2;

   // size of a two-byte field (topic length, packet id)
   localparam logic [16:0] FIELD_BYTES = 17'd2;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [1:0]  qos_level;
      logic [27:0] remaining_length;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  byte_class;
      logic [7:0]  echo_byte;
      logic [15:0] topic_length;
      logic [15:0] packet_id;
      logic        packet_done;
      logic [1:0]  error_code;
   } rsp_item_type;

   // request held in the input register
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } hold_type;

endpackage

### rtl/core/mpbp_req_if.sv
// ----------------------------------------------------------------------------
// mpbp_req_if
// Request channel: one body byte with its packet-start sideband.
// ----------------------------------------------------------------------------
interface mpbp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        first_byte;
   logic [1:0]  qos_level;
   logic [27:0] remaining_length;

   modport source (output valid, output data_byte, output first_byte,
                   output qos_level, output remaining_length, input ready);
   modport sink   (input valid, input data_byte, input first_byte,
                   input qos_level, input remaining_length, output ready);
endinterface

### rtl/core/mpbp_rsp_if.sv
// ----------------------------------------------------------------------------
// mpbp_rsp_if
// Response channel: classification and decoded fields of one body byte.
// ----------------------------------------------------------------------------
interface mpbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  byte_class;
   logic [7:0]  echo_byte;
   logic [15:0] topic_length;
   logic [15:0] packet_id;
   logic        packet_done;
   logic [1:0]  error_code;

   modport source (output valid, output byte_class, output echo_byte,
                   output topic_length, output packet_id, output packet_done,
                   output error_code, input ready);
   modport sink   (input valid, input byte_class, input echo_byte,
                   input topic_length, input packet_id, input packet_done,
                   input error_code, output ready);
endinterface

### rtl/core/mpbp_input_stage.sv
// ----------------------------------------------------------------------------
// mpbp_input_stage
// Input register: captures one request and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module mpbp_input_stage (
   input  logic             clock,
   input  logic             reset,
   mpbp_req_if.sink         req_chan,
   input  logic             take,
   output mpbp_pkg::hold_type hold
);
   import mpbp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   // free when empty or when the held request moves on this cycle
   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.data_byte        <= req_chan.data_byte;
         item_ff.first_byte       <= req_chan.first_byte;
         item_ff.qos_level        <= req_chan.qos_level;
         item_ff.remaining_length <= req_chan.remaining_length;
      end
   end

   assign hold.valid = valid_ff;
   assign hold.item  = item_ff;
endmodule

### rtl/core/mpbp_parser.sv
// ----------------------------------------------------------------------------
// mpbp_parser
// Parse state and per-byte next-state logic; the state advances when the
// held request is taken into the result register.
// ----------------------------------------------------------------------------
module mpbp_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  mpbp_pkg::hold_type     hold,
   input  logic                   take,
   output mpbp_pkg::rsp_item_type result
);
   import mpbp_pkg::*;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [15:0] count_ff, count_in, cur_count;
   logic [7:0]  high_ff, high_in, cur_high;
   logic [15:0] tlen_ff, tlen_in, cur_tlen;
   logic [15:0] pid_ff, pid_in, cur_pid;
   logic [27:0] left_ff, left_in, cur_left;
   logic [16:0] hdr_ff, hdr_in, cur_hdr;
   logic [1:0]  qos_ff, qos_in, cur_qos;
   logic [1:0]  err_ff, err_in, cur_err;
   logic [27:0] rem_ff, rem_in, cur_rem;

   logic [7:0]  b;
   logic [15:0] word;
   logic [16:0] hdr_eff;
   logic [28:0] diff;
   logic        short_len;
   logic        start_pay;
   logic [15:0] count_dec;
   logic [27:0] left_dec;
   logic [2:0]  cls;
   logic        done;

   assign b    = hold.item.data_byte;
   assign word = {cur_high, b};

   // state seen by this byte: a packet start clears the parse
   always_comb begin
      cur_phase = phase_ff;
      cur_count = count_ff;
      cur_high  = high_ff;
      cur_tlen  = tlen_ff;
      cur_pid   = pid_ff;
      cur_left  = left_ff;
      cur_hdr   = hdr_ff;
      cur_qos   = qos_ff;
      cur_err   = err_ff;
      cur_rem   = rem_ff;
      if (hold.item.first_byte) begin
         cur_phase = PH_TLEN;
         cur_count = '0;
         cur_high  = '0;
         cur_tlen  = '0;
         cur_pid   = '0;
         cur_left  = '0;
         cur_hdr   = '0;
         cur_qos   = hold.item.qos_level;
         cur_err   = ERR_NONE;
         cur_rem   = hold.item.remaining_length;
      end
   end

   // header length check and payload size
   assign hdr_eff   = (cur_phase == PH_PKTID) ? cur_hdr + FIELD_BYTES : cur_hdr;
   assign diff      = {1'b0, cur_rem} - {12'b0, hdr_eff};
   assign short_len = diff[28] || (cur_rem == 28'd0);
   assign count_dec = cur_count - 16'd1;
   assign left_dec  = cur_left - 28'd1;

   // per-byte next state
   always_comb begin
      phase_in  = cur_phase;
      count_in  = cur_count;
      high_in   = cur_high;
      tlen_in   = cur_tlen;
      pid_in    = cur_pid;
      left_in   = cur_left;
      hdr_in    = cur_hdr;
      qos_in    = cur_qos;
      err_in    = cur_err;
      rem_in    = cur_rem;
      cls       = CLS_NONE;
      done      = 1'b0;
      start_pay = 1'b0;
      unique case (cur_phase)
         PH_TLEN: begin
            cls = CLS_TLEN;
            if (cur_count == 16'd0) begin
               high_in  = b;
               count_in = 16'd1;
            end else begin
               tlen_in = word;
               if (word == 16'd0) begin
                  err_in   = ERR_ZERO_TOPIC;
                  phase_in = PH_FAIL;
               end else begin
                  hdr_in   = {1'b0, word} + FIELD_BYTES;
                  count_in = word;
                  phase_in = PH_TOPIC;
               end
            end
         end
         PH_TOPIC: begin
            cls      = CLS_TOPIC;
            count_in = count_dec;
            if (count_dec == 16'd0) begin
               if (cur_qos != 2'd0) begin
                  phase_in = PH_PKTID;
               end else begin
                  start_pay = 1'b1;
               end
            end
         end
         PH_PKTID: begin
            cls = CLS_PKTID;
            if (cur_count == 16'd0) begin
               high_in  = b;
               count_in = 16'd1;
            end else begin
               pid_in    = word;
               count_in  = '0;
               hdr_in    = hdr_eff;
               start_pay = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            cls     = CLS_PAYLOAD;
            left_in = left_dec;
            if (left_dec == 28'd0) begin
               phase_in = PH_DONE;
               done     = 1'b1;
            end
         end
         default: begin
            cls = CLS_NONE;
         end
      endcase

      // end of header: fail on shortfall, else start or finish the payload
      if (start_pay) begin
         if (short_len) begin
            err_in   = ERR_SHORT;
            phase_in = PH_FAIL;
         end else begin
            left_in = diff[27:0];
            if (diff[27:0] == 28'd0) begin
               phase_in = PH_DONE;
               done     = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         high_ff  <= '0;
         tlen_ff  <= '0;
         pid_ff   <= '0;
         left_ff  <= '0;
         hdr_ff   <= '0;
         qos_ff   <= '0;
         err_ff   <= ERR_NONE;
         rem_ff   <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         high_ff  <= high_in;
         tlen_ff  <= tlen_in;
         pid_ff   <= pid_in;
         left_ff  <= left_in;
         hdr_ff   <= hdr_in;
         qos_ff   <= qos_in;
         err_ff   <= err_in;
         rem_ff   <= rem_in;
      end
   end

   assign result.byte_class   = cls;
   assign result.echo_byte    = b;
   assign result.topic_length = tlen_in;
   assign result.packet_id    = pid_in;
   assign result.packet_done  = done;
   assign result.error_code   = err_in;
endmodule

### rtl/core/mpbp_output_stage.sv
// ----------------------------------------------------------------------------
// mpbp_output_stage
// Result register: holds one response until the sink takes it and tells
// the input side when the held request may move in.
// ----------------------------------------------------------------------------
module mpbp_output_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  mpbp_pkg::rsp_item_type result,
   output logic                   take,
   mpbp_rsp_if.source             rsp_chan
);
   import mpbp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;

   // move in when the register is empty or drains this cycle
   assign take = item_valid && (!valid_ff || rsp_chan.ready);

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.byte_class   = data_ff.byte_class;
   assign rsp_chan.echo_byte    = data_ff.echo_byte;
   assign rsp_chan.topic_length = data_ff.topic_length;
   assign rsp_chan.packet_id    = data_ff.packet_id;
   assign rsp_chan.packet_done  = data_ff.packet_done;
   assign rsp_chan.error_code   = data_ff.error_code;
endmodule

### rtl/core/mqtt_publish_body_parser_core.sv
// ----------------------------------------------------------------------------
// mqtt_publish_body_parser_core
// Parses a publish packet body one byte per request and returns one
// response per byte.
// ----------------------------------------------------------------------------
// Takes one body byte per clock and returns one response per byte, in order.
// A byte sits in the input register while the parse logic classifies it
// and updates the parse state, then lands in the result register. The
// input register frees itself whenever its byte moves on, so a request
// is taken every clock while the sink keeps taking responses; a stalled
// sink holds at most one response and one request before request ready
// drops. A request with first_byte set samples QoS and remaining length
// and restarts the parse.
// ----------------------------------------------------------------------------
module mqtt_publish_body_parser_core (
   input  logic       clock,
   input  logic       reset,
   mpbp_req_if.sink   req_chan,
   mpbp_rsp_if.source rsp_chan
);
   import mpbp_pkg::*;

   hold_type     hold;
   rsp_item_type result;
   logic         take;

   // input register
   mpbp_input_stage u_input (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .hold     (hold)
   );

   // parse state and per-byte logic
   mpbp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .hold   (hold),
      .take   (take),
      .result (result)
   );

   // result register
   mpbp_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .item_valid (hold.valid),
      .result     (result),
      .take       (take),
      .rsp_chan   (rsp_chan)
   );
endmodule

### rtl/core/mpbp_checker.sv
// ----------------------------------------------------------------------------
// mpbp_checker
// Port-level checks on the parser's responses, bound to the top level.
// ----------------------------------------------------------------------------
module mpbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_byte_class,
   input logic [7:0]  rsp_echo_byte,
   input logic [15:0] rsp_topic_length,
   input logic        rsp_packet_done,
   input logic [1:0]  rsp_error_code
);
   import mpbp_pkg::*;

   // stalled response keeps its byte and class
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_byte)
                                 && $stable(rsp_byte_class))
      else $error("response changed while stalled");

   // a finishing byte is consumed and error free
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_done |->
         rsp_byte_class != CLS_NONE && rsp_error_code == ERR_NONE)
      else $error("packet done on unconsumed or failed byte");

   // zero topic error reports a zero topic length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_ZERO_TOPIC |-> rsp_topic_length == 16'd0)
      else $error("zero topic error with nonzero topic length");

   // bytes past the topic length field need a nonzero topic length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_class == CLS_TOPIC || rsp_byte_class == CLS_PKTID
                    || rsp_byte_class == CLS_PAYLOAD) |-> rsp_topic_length != 16'd0)
      else $error("topic, id or payload byte without topic length");
endmodule

bind mqtt_publish_body_parser_core mpbp_checker u_mpbp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_byte_class   (rsp_chan.byte_class),
   .rsp_echo_byte    (rsp_chan.echo_byte),
   .rsp_topic_length (rsp_chan.topic_length),
   .rsp_packet_done  (rsp_chan.packet_done),
   .rsp_error_code   (rsp_chan.error_code)
);

### tb/mqtt_publish_body_parser_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mqtt_publish_body_parser_core_test
// Feeds publish packet bodies byte by byte through the parser and compares
// every response, field by field, with a cycle-free model of the parse kept
// in the bench, or a typed row's own response. A short directed table comes
// first, then random packets, some broken on purpose, random gaps and response stalls.
// ----------------------------------------------------------------------------
module mqtt_publish_body_parser_core_test;
   import mpbp_pkg::*;

   localparam int BYTE_TARGET    = 1100;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct {
      req_item_type req;
      bit           typed;
      rsp_item_type rsp;
   } stim_row_type;

   logic clock;
   logic reset;

   mpbp_req_if req_chan ();
   mpbp_rsp_if rsp_chan ();

   mqtt_publish_body_parser_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // parse state of the bench model
   phase_type   phase_m;
   logic [15:0] count_m;
   logic [7:0]  high_m;
   logic [15:0] topic_len_m;
   logic [15:0] packet_id_m;
   logic [27:0] payload_left_m;
   logic [16:0] header_len_m;
   logic [1:0]  qos_m;
   logic [1:0]  error_m;
   logic [27:0] rem_len_m;

   rsp_item_type classified_q[$];
   stim_row_type directed_rows[$];
   int           parsed_bytes;
   int           fail_count;
   int           burst_left;
   int           idle_cycles;

   // receiver stall pattern
   int           ready_mode;
   int           ready_window;
   logic [7:0]   stall_mask;
   logic [2:0]   mask_idx;

   always #1 clock = ~clock;

   // header complete: start or finish the payload, or fail on a shortfall
   function automatic logic open_payload();
      if (rem_len_m < {11'd0, header_len_m} || rem_len_m == 28'd0) begin
         error_m = ERR_SHORT;
         phase_m = PH_FAIL;
         return 1'b0;
      end
      payload_left_m = rem_len_m - {11'd0, header_len_m};
      if (payload_left_m == 28'd0) begin
         phase_m = PH_DONE;
         return 1'b1;
      end
      phase_m = PH_PAYLOAD;
      return 1'b0;
   endfunction

   // advance the model by one byte and return its classification
   function automatic rsp_item_type classify_byte(input req_item_type it);
      rsp_item_type r;
      logic         done;
      r.byte_class = CLS_NONE;
      done = 1'b0;
      if (it.first_byte) begin
         qos_m          = it.qos_level;
         rem_len_m      = it.remaining_length;
         phase_m        = PH_TLEN;
         count_m        = '0;
         high_m         = '0;
         topic_len_m    = '0;
         packet_id_m    = '0;
         payload_left_m = '0;
         header_len_m   = '0;
         error_m        = ERR_NONE;
      end
      case (phase_m)
         PH_TLEN: begin
            r.byte_class = CLS_TLEN;
            if (count_m == 16'd0) begin
               high_m  = it.data_byte;
               count_m = 16'd1;
            end else begin
               topic_len_m = {high_m, it.data_byte};
               if (topic_len_m == 16'd0) begin
                  error_m = ERR_ZERO_TOPIC;
                  phase_m = PH_FAIL;
               end else begin
                  header_len_m = {1'b0, topic_len_m} + FIELD_BYTES;
                  count_m      = topic_len_m;
                  phase_m      = PH_TOPIC;
               end
            end
         end
         PH_TOPIC: begin
            r.byte_class = CLS_TOPIC;
            count_m = count_m - 16'd1;
            if (count_m == 16'd0) begin
               if (qos_m != 2'd0) phase_m = PH_PKTID;
               else done = open_payload();
            end
         end
         PH_PKTID: begin
            r.byte_class = CLS_PKTID;
            if (count_m == 16'd0) begin
               high_m  = it.data_byte;
               count_m = 16'd1;
            end else begin
               packet_id_m  = {high_m, it.data_byte};
               count_m      = 16'd0;
               header_len_m = header_len_m + FIELD_BYTES;
               done = open_payload();
            end
         end
         PH_PAYLOAD: begin
            r.byte_class = CLS_PAYLOAD;
            payload_left_m = payload_left_m - 28'd1;
            if (payload_left_m == 28'd0) begin
               phase_m = PH_DONE;
               done = 1'b1;
            end
         end
         default: begin
            r.byte_class = CLS_NONE;
         end
      endcase
      r.echo_byte    = it.data_byte;
      r.topic_length = topic_len_m;
      r.packet_id    = packet_id_m;
      r.packet_done  = done;
      r.error_code   = error_m;
      return r;
   endfunction

   task automatic add_row(input logic [7:0] data, input logic first, input logic [1:0] qos,
                          input logic [27:0] rem, input bit typed, input logic [2:0] cls,
                          input logic [15:0] tlen, input logic [15:0] pid,
                          input logic done, input logic [1:0] err);
      stim_row_type row;
      row.req.data_byte        = data;
      row.req.first_byte       = first;
      row.req.qos_level        = qos;
      row.req.remaining_length = rem;
      row.typed                = typed;
      row.rsp.byte_class       = cls;
      row.rsp.echo_byte        = data;
      row.rsp.topic_length     = tlen;
      row.rsp.packet_id        = pid;
      row.rsp.packet_done      = done;
      row.rsp.error_code       = err;
      directed_rows = {directed_rows, row};
   endtask

   // drive one request, starting and ending at a falling edge
   task automatic send_request(input req_item_type it, input bit typed,
                               input rsp_item_type typed_rsp);
      rsp_item_type r;
      int           gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid            <= 1'b1;
      req_chan.data_byte        <= it.data_byte;
      req_chan.first_byte       <= it.first_byte;
      req_chan.qos_level        <= it.qos_level;
      req_chan.remaining_length <= it.remaining_length;
      do @(posedge clock); while (!req_chan.ready);
      r = classify_byte(it);
      if (r.byte_class != CLS_NONE) parsed_bytes++;
      if (typed) r = typed_rsp;
      classified_q = {classified_q, r};
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] data, input logic first, input logic [1:0] qos,
                            input logic [27:0] rem);
      req_item_type it;
      it.data_byte        = data;
      it.first_byte       = first;
      it.qos_level        = qos;
      it.remaining_length = rem;
      send_request(it, 1'b0, '0);
   endtask

   // one random packet: mostly well formed, some short, truncated or noisy
   task automatic send_packet();
      logic [1:0]  qos;
      logic [15:0] tlen;
      logic [27:0] rem;
      int          plen;
      int          hdr;
      int          total;
      int          kind;
      logic [7:0]  data;
      qos  = 2'($urandom_range(0, 3));
      kind = $urandom_range(0, 99);
      if (kind < 5) tlen = 16'd0;
      else if (kind < 8) tlen = 16'($urandom_range(200, 300));
      else tlen = 16'($urandom_range(1, 6));
      plen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      hdr  = tlen + 2 + ((qos != 2'd0) ? 2 : 0);
      kind = $urandom_range(0, 99);
      if (kind < 8) rem = 28'($urandom_range(0, hdr - 1));
      else if (kind < 13) rem = 28'($urandom);
      else rem = 28'(hdr + plen);
      total = 2 + ((tlen == 16'd0) ? 0 : hdr - 2 + plen);
      // broken sequence: cut the packet short
      if ($urandom_range(0, 99) < 8) total = $urandom_range(1, total);
      for (int i = 0; i < total; i++) begin
         if (i == 0) data = tlen[15:8];
         else if (i == 1) data = tlen[7:0];
         else data = 8'($urandom_range(0, 255));
         if (i == 0) send_byte(data, 1'b1, qos, rem);
         else send_byte(data, 1'b0, 2'($urandom_range(0, 3)), 28'($urandom));
      end
      // stray bytes between packets
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 3))
            send_byte(8'($urandom_range(0, 255)), 1'b0, 2'($urandom_range(0, 3)),
                      28'($urandom));
      end
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // response check against the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (classified_q.size() == 0) begin
            $error("response with no request outstanding: class %0d byte 0x%0h",
                   rsp_chan.byte_class, rsp_chan.echo_byte);
            fail_count++;
         end else begin
            want = classified_q.pop_front();
            compare_field("byte_class", want.byte_class, rsp_chan.byte_class);
            compare_field("echo_byte", want.echo_byte, rsp_chan.echo_byte);
            compare_field("topic_length", want.topic_length, rsp_chan.topic_length);
            compare_field("packet_id", want.packet_id, rsp_chan.packet_id);
            compare_field("packet_done", want.packet_done, rsp_chan.packet_done);
            compare_field("error_code", want.error_code, rsp_chan.error_code);
         end
      end
   end

   // receiver: windows of always ready, random stalls and a rotating mask
   always @(negedge clock) begin
      if (ready_window == 0) begin
         ready_mode   = $urandom_range(0, 2);
         stall_mask   = 8'($urandom_range(1, 255));
         ready_window = $urandom_range(20, 120);
      end
      ready_window--;
      mask_idx = mask_idx + 3'd1;
      case (ready_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         default: rsp_chan.ready <= stall_mask[mask_idx];
      endcase
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clock                     = 1'b0;
      reset                     = 1'b1;
      req_chan.valid            = 1'b0;
      req_chan.data_byte        = '0;
      req_chan.first_byte       = 1'b0;
      req_chan.qos_level        = '0;
      req_chan.remaining_length = '0;
      rsp_chan.ready            = 1'b0;
      ready_window              = 0;
      ready_mode                = 0;
      stall_mask                = 8'hFF;
      mask_idx                  = '0;
      parsed_bytes              = 0;
      fail_count                = 0;
      burst_left                = 0;
      phase_m                   = PH_IDLE;
      count_m                   = '0;
      high_m                    = '0;
      topic_len_m               = '0;
      packet_id_m               = '0;
      payload_left_m            = '0;
      header_len_m              = '0;
      qos_m                     = '0;
      error_m                   = ERR_NONE;
      rem_len_m                 = '0;

      // byte after reset, zero topic length and stray byte after failure
      add_row(8'hFF, 1'b0, 2'd0, 28'd0, 1'b1, CLS_NONE, 16'h0000, 16'h0000, 1'b0, ERR_NONE);
      add_row(8'h00, 1'b1, 2'd0, 28'd0, 1'b1, CLS_TLEN, 16'h0000, 16'h0000, 1'b0, ERR_NONE);
      add_row(8'h00, 1'b0, 2'd0, 28'd0, 1'b1, CLS_TLEN, 16'h0000, 16'h0000, 1'b0,
              ERR_ZERO_TOPIC);
      add_row(8'hAA, 1'b0, 2'd0, 28'd0, 1'b1, CLS_NONE, 16'h0000, 16'h0000, 1'b0,
              ERR_ZERO_TOPIC);
      // qos 0 with empty payload, then a byte after done
      add_row(8'h00, 1'b1, 2'd0, 28'd5, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'h03, 1'b0, 2'd0, 28'd0, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'h61, 1'b0, 2'd0, 28'd0, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'h62, 1'b0, 2'd0, 28'd0, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'h63, 1'b0, 2'd0, 28'd0, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'h80, 1'b0, 2'd3, 28'h0FFFFFFF, 1'b0, '0, '0, '0, 1'b0, '0);
      // qos 1 shortfall found on the second packet id byte
      add_row(8'h00, 1'b1, 2'd1, 28'd4, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'h01, 1'b0, 2'd0, 28'd0, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'h7A, 1'b0, 2'd0, 28'd0, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 2'd0, 28'd0, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 2'd0, 28'd0, 1'b1, CLS_PKTID, 16'h0001, 16'hFFFF, 1'b0, ERR_SHORT);
      // qos code 3, largest remaining length and topic length, then abandoned
      add_row(8'hFF, 1'b1, 2'd3, 28'h0FFFFFFF, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 2'd0, 28'd0, 1'b1, CLS_TLEN, 16'hFFFF, 16'h0000, 1'b0, ERR_NONE);
      // new packet mid-topic: qos 2 with a one-byte payload
      add_row(8'h00, 1'b1, 2'd2, 28'd6, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'h01, 1'b0, 2'd0, 28'd0, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'h41, 1'b0, 2'd0, 28'd0, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'h12, 1'b0, 2'd0, 28'd0, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'h34, 1'b0, 2'd0, 28'd0, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'h00, 1'b0, 2'd0, 28'd0, 1'b0, '0, '0, '0, 1'b0, '0);
      // qos 0 shortfall found on the last topic byte
      add_row(8'h00, 1'b1, 2'd0, 28'd2, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'h01, 1'b0, 2'd0, 28'd0, 1'b0, '0, '0, '0, 1'b0, '0);
      add_row(8'h55, 1'b0, 2'd0, 28'd0, 1'b1, CLS_TOPIC, 16'h0001, 16'h0000, 1'b0, ERR_SHORT);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      while (parsed_bytes < BYTE_TARGET)
         send_packet();

      req_chan.valid <= 1'b0;
      while (classified_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
